// ===== hw/rtl/cse_pkg.sv =====
// Shared types and constants of the cycle sort engine.
// No dependencies; imported by cse_store and cycle_sort_engine_core.
package cse_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = VALUE_W;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Request from the sequencer to the element store
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_addr raddr;
    } t_store_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_ITEM,
        S_GET_ITEM,
        S_SCAN_PRE,
        S_SCAN,
        S_SKIP_RD,
        S_SKIP_CMP,
        S_NEXT,
        S_EMIT_PRE,
        S_EMIT
    } t_state;

endpackage

// ===== hw/rtl/cycle_sort_engine_core.sv =====
// Cycle sort engine: loads signed values, sorts them in place by cycle sort, emits them ascending.
// Load: one transaction per cycle while busy is low; the transaction marked last starts the sort.
// Sort: for n stored values, one memory read per cycle while counting smaller elements,
// plus a read and a compare step per equal value skipped.
// Output: n results on consecutive cycles after the sort ends; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) empties the list and clears the internal overflow flag.
module cycle_sort_engine_core
    import cse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_sorted_value,
    output logic               o_final_res,
    output logic               o_overflow
);

    // Sequencer state and control registers
    t_state r_state, n_state;
    t_cnt   r_count, n_count;     // stored elements
    logic   r_dropped, n_dropped; // a transaction was dropped on a full store
    t_cnt   r_start, n_start;     // start position of the current cycle
    t_cnt   r_pos, n_pos;         // target slot of the item in hand
    t_cnt   r_idx, n_idx;         // scan / emit index
    logic   r_first, n_first;     // first placement of the current start
    t_data  r_item, n_item;       // item being rotated

    // Result registers
    logic   r_out_vld;
    t_data  r_out_value;
    logic   r_out_final;
    logic   r_out_ovf;

    // Store interface
    t_store_req w_req;
    t_data      w_wdata;
    t_data      w_rdata;

    // Shared compare unit and helpers
    logic  w_lt;
    logic  w_eq;
    logic  w_full;
    t_cnt  w_cnt_ld;
    t_cnt  w_pos_scan;
    logic  w_scan_last;
    logic  w_emit_last;
    logic  w_accept;

    cse_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_accept    = start && !busy;
    assign w_full      = (r_count == t_cnt'(MAX_ITEMS));
    assign w_cnt_ld    = w_full ? r_count : r_count + t_cnt'(1);
    assign w_lt        = $signed(w_rdata) < $signed(r_item);
    assign w_eq        = (w_rdata == r_item);
    assign w_pos_scan  = w_lt ? r_pos + t_cnt'(1) : r_pos;
    assign w_scan_last = (r_idx == r_count - t_cnt'(1));
    assign w_emit_last = (r_idx == r_count - t_cnt'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_last) begin
                    n_state = (w_cnt_ld >= t_cnt'(2)) ? S_LOAD_ITEM : S_EMIT_PRE;
                end
            end
            S_LOAD_ITEM: n_state = S_GET_ITEM;
            S_GET_ITEM:  n_state = S_SCAN_PRE;
            S_SCAN_PRE:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = (r_first && w_pos_scan == r_start) ? S_NEXT : S_SKIP_RD;
                end
            end
            S_SKIP_RD: begin
                n_state = (r_pos >= r_count) ? S_NEXT : S_SKIP_CMP;
            end
            S_SKIP_CMP: begin
                if (w_eq) begin
                    n_state = S_SKIP_RD;
                end else begin
                    n_state = (r_pos == r_start) ? S_NEXT : S_SCAN_PRE;
                end
            end
            S_NEXT: begin
                // another start position only while start+1 < n after the advance
                if (({1'b0, r_start} + (CNT_W+1)'(2)) < {1'b0, r_count}) begin
                    n_state = S_LOAD_ITEM;
                end else begin
                    n_state = S_EMIT_PRE;
                end
            end
            S_EMIT_PRE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control and next register values
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_start   = r_start;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_first   = r_first;
        n_item    = r_item;
        w_req     = '0;
        w_wdata   = r_item;
        case (r_state)
            S_IDLE: begin
                // store the key while room is left, otherwise drop it and flag it
                w_wdata     = i_value;
                w_req.waddr = r_count[ADDR_W-1:0];
                if (w_accept) begin
                    w_req.we = !w_full;
                    n_count  = w_cnt_ld;
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    n_start = '0;
                    n_first = 1'b1;
                end
            end
            S_LOAD_ITEM: begin
                w_req.raddr = r_start[ADDR_W-1:0];
            end
            S_GET_ITEM: begin
                n_item = w_rdata;
            end
            S_SCAN_PRE: begin
                w_req.raddr = ADDR_W'(r_start + t_cnt'(1));
                n_idx       = r_start + t_cnt'(1);
                n_pos       = r_start;
            end
            S_SCAN: begin
                // count smaller later elements, one per cycle
                w_req.raddr = ADDR_W'(r_idx + t_cnt'(1));
                n_idx       = r_idx + t_cnt'(1);
                n_pos       = w_pos_scan;
            end
            S_SKIP_RD: begin
                w_req.raddr = r_pos[ADDR_W-1:0];
            end
            S_SKIP_CMP: begin
                if (w_eq) begin
                    n_pos = r_pos + t_cnt'(1);
                end else begin
                    // swap: drop the item into its slot, take the old occupant
                    w_req.we    = 1'b1;
                    w_req.waddr = r_pos[ADDR_W-1:0];
                    w_wdata     = r_item;
                    n_item      = w_rdata;
                    n_first     = 1'b0;
                end
            end
            S_NEXT: begin
                n_start = r_start + t_cnt'(1);
                n_first = 1'b1;
            end
            S_EMIT_PRE: begin
                w_req.raddr = '0;
                n_idx       = '0;
            end
            S_EMIT: begin
                w_req.raddr = ADDR_W'(r_idx + t_cnt'(1));
                n_idx       = r_idx + t_cnt'(1);
                if (w_emit_last) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_out_vld <= (r_state == S_EMIT);
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_first <= n_first;
        r_item  <= n_item;
        if (r_state == S_EMIT) begin
            r_out_value <= w_rdata;
            r_out_final <= w_emit_last;
            r_out_ovf   <= r_dropped;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_out_vld;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;
    assign o_overflow     = r_out_ovf;

    // The final result closes the list: no strobe follows it directly
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_res) |=> !o_valid)
        else $error("result strobe directly after the final result");

    // List length holds while the sequencer is busy
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("element count changed during sort or output");

    // A swap writes only inside the stored list
    a_swap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP_CMP && w_req.we) |-> ({1'b0, w_req.waddr} < r_count))
        else $error("swap outside the stored list");

    // Target slot never runs past the list end while scanning
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SKIP_CMP) |-> (r_pos < r_count))
        else $error("target slot beyond list end");

endmodule

// ===== hw/rtl/cse_store.sv =====
// Element store of the cycle sort engine: one write port, one registered read port.
// Depends on cse_pkg.
module cse_store
    import cse_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    input  t_data      i_wdata,
    output t_data      o_rdata
);

    t_data r_mem [MAX_ITEMS];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
